// ----- src/bracket_balance_checker_defines.svh -----
// Assertion macros for the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define BBC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBC_ASSERT_ALWAYS(lbl, cond, msg)

`define BBC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/bbc_pkg.sv -----
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int POS_BITS    = 16;
    localparam int OUT_BITS    = 16;
    localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

    typedef enum logic [1:0] {
        KIND_ROUND,
        KIND_CURLY,
        KIND_SQUARE,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        logic [POS_BITS-1:0] pos;
        kind_t               kind;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] error_pos;
        logic                overflow;
    } out_beat_t;

endpackage

// ----- src/bbc_stack_cell.sv -----
module bbc_stack_cell
    import bbc_pkg::*;
(
    input  logic      clk,
    input  stack_op_t op,
    input  entry_t    from_above,
    input  entry_t    from_below,
    output entry_t    entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.push)
        begin
            entry_next = from_above;
        end
        else if (op.pop)
        begin
            entry_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- src/bracket_balance_checker.sv -----
// Bracket balance checker. Takes one text byte per clock with a last mark and,
// on the last byte, gives one beat: the position of the first bad bracket, the
// innermost unclosed opener, or zero when balanced, plus an overflow flag. A
// byte is taken every cycle; the result appears in the cycle after the last
// byte is taken, from an output register, and input stalls only while that
// register holds an untaken result. The nesting stack is a shift chain of
// STACK_DEPTH cells with the top in the first cell, so a push or pop moves
// every cell at once. No clearing pass is needed after reset.
`include "bracket_balance_checker_defines.svh"

module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_beat,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_beat
);

    logic [COUNT_BITS-1:0] count_reg,    count_next;
    logic [POS_BITS-1:0]   pos_reg,      pos_next;
    logic [POS_BITS-1:0]   err_pos_reg,  err_pos_next;
    logic                  err_reg,      err_next;
    logic                  ovf_reg,      ovf_next;
    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_reg,      out_next;

    entry_t    cells [STACK_DEPTH];
    entry_t    new_entry;
    stack_op_t op;

    logic                in_fire;
    logic                is_space;
    kind_t               open_kind;
    kind_t               close_kind;
    logic                active;
    logic [POS_BITS-1:0] pos_inc;
    logic                full;
    logic                ovf_set;
    logic                err_set;
    logic [POS_BITS-1:0] result_pos;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    always_comb
    begin
        is_space = in_beat.ch inside {8'h20, [8'h09:8'h0D]};
        case (in_beat.ch)
            CH_OPEN_ROUND:  open_kind = KIND_ROUND;
            CH_OPEN_CURLY:  open_kind = KIND_CURLY;
            CH_OPEN_SQUARE: open_kind = KIND_SQUARE;
            default:        open_kind = KIND_NONE;
        endcase
        case (in_beat.ch)
            CH_CLOSE_ROUND:  close_kind = KIND_ROUND;
            CH_CLOSE_CURLY:  close_kind = KIND_CURLY;
            CH_CLOSE_SQUARE: close_kind = KIND_SQUARE;
            default:         close_kind = KIND_NONE;
        endcase
    end

    always_comb
    begin
        active  = in_fire & ~err_reg & ~ovf_reg & ~is_space;
        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        full    = (count_reg == COUNT_BITS'(STACK_DEPTH));
        op.push = active & (open_kind != KIND_NONE) & ~full;
        ovf_set = active & (open_kind != KIND_NONE) & full;
        op.pop  = active & (close_kind != KIND_NONE) & (count_reg != '0)
                  & (cells[0].kind == close_kind);
        err_set = active & (close_kind != KIND_NONE) & ~op.pop;
        new_entry.pos  = pos_inc;
        new_entry.kind = open_kind;
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = active ? pos_inc : pos_reg;
        err_next     = err_reg | err_set;
        ovf_next     = ovf_reg | ovf_set;
        err_pos_next = (err_set | ovf_set) ? pos_inc : err_pos_reg;
        if (op.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (op.pop)
        begin
            count_next = count_reg - 1'b1;
        end

        if (err_next | ovf_next)
        begin
            result_pos = err_pos_next;
        end
        else if (count_next == '0)
        begin
            result_pos = '0;
        end
        else if (op.push)
        begin
            result_pos = pos_inc;
        end
        else if (op.pop)
        begin
            result_pos = cells[1].pos;
        end
        else
        begin
            result_pos = cells[0].pos;
        end

        out_next           = out_reg;
        out_valid_next     = out_valid_reg & out_stall;
        if (in_fire & in_beat.last)
        begin
            out_next.error_pos = OUT_BITS'(result_pos);
            out_next.overflow  = ovf_next;
            out_valid_next     = 1'b1;
            count_next         = '0;
            pos_next           = '0;
            err_next           = 1'b0;
            ovf_next           = 1'b0;
            err_pos_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            err_pos_reg   <= '0;
            err_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            err_pos_reg   <= err_pos_next;
            err_reg       <= err_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        entry_t above;
        entry_t below;
        if (i == 0)
        begin : g_top
            assign above = new_entry;
        end
        else
        begin : g_mid
            assign above = cells[i-1];
        end
        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = cells[i];
        end
        else
        begin : g_inner
            assign below = cells[i+1];
        end
        bbc_stack_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .entry      (cells[i])
        );
    end

    `BBC_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_BITS'(STACK_DEPTH), "stack count past depth")
    `BBC_ASSERT_NEXT(a_last_clears, in_fire && in_beat.last, out_valid && count_reg == '0 && pos_reg == '0 && !err_reg && !ovf_reg, "last beat did not give a result and clear")
    `BBC_ASSERT_NEXT(a_halt_sticky, in_fire && !in_beat.last && (err_reg || ovf_reg), $stable(count_reg) && $stable(pos_reg) && $stable(err_pos_reg), "state moved after checking ended")

endmodule

// ----- tb/sv/bracket_balance_checker_tb.sv -----
`timescale 1ns / 1ps

module bracket_balance_checker_tb;
    import bbc_pkg::*;

    localparam int          LIMIT        = 2_000_000;
    localparam int          RANDOM_BYTES = 1400;
    localparam int          HOLD_CYCLES  = 300;
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_TAB       = 8'h09;
    localparam logic [7:0]  CH_CR        = 8'h0D;
    localparam logic [7:0]  CH_FILL      = 8'h78;

    typedef struct {
        int                  pre_n;
        logic [7:0]          pre_ch;
        string               body;
        int                  post_n;
        logic [7:0]          post_ch;
        logic                typed;
        logic [OUT_BITS-1:0] want_pos;
        logic                want_ovf;
    } text_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_beat;

    logic      beat_typed = 1'b0;
    out_beat_t beat_want  = '0;

    logic [POS_BITS-1:0] open_pos [STACK_DEPTH];
    kind_t               open_kinds [STACK_DEPTH];
    int unsigned         open_n   = 0;
    logic [POS_BITS-1:0] byte_pos = '0;
    logic [POS_BITS-1:0] err_at   = '0;
    bit                  err_seen = 1'b0;
    bit                  ovf_seen = 1'b0;

    out_beat_t   expected_results [$];
    logic [7:0]  text_q [$];
    int unsigned fail_count = 0;
    int unsigned cycles     = 0;
    bit          tx_calm    = 1'b0;
    bit          rx_calm    = 1'b0;
    bit          hold_req   = 1'b0;

    text_row_t rows [22] = '{
        '{0, CH_FILL, "a", 0, CH_FILL, 1'b1, 16'd0, 1'b0},
        '{0, CH_FILL, "()", 0, CH_FILL, 1'b1, 16'd0, 1'b0},
        '{0, CH_FILL, "{[()]}", 0, CH_FILL, 1'b1, 16'd0, 1'b0},
        '{0, CH_FILL, ")", 0, CH_FILL, 1'b1, 16'd1, 1'b0},
        '{0, CH_FILL, "(]", 0, CH_FILL, 1'b1, 16'd2, 1'b0},
        '{0, CH_FILL, "([)]", 0, CH_FILL, 1'b1, 16'd3, 1'b0},
        '{0, CH_FILL, "( x", 0, CH_FILL, 1'b1, 16'd1, 1'b0},
        '{0, CH_FILL, "\011\012\013\014\015 ", 0, CH_FILL, 1'b1, 16'd0, 1'b0},
        '{0, CH_FILL, "}(((", 0, CH_FILL, 1'b1, 16'd1, 1'b0},
        '{0, CH_FILL, "[x]{ ", 0, CH_FILL, 1'b1, 16'd4, 1'b0},
        '{STACK_DEPTH, CH_OPEN_ROUND, "(", 0, CH_FILL,
          1'b1, 16'(STACK_DEPTH + 1), 1'b1},
        '{STACK_DEPTH, CH_OPEN_ROUND, "(}]x", 0, CH_FILL,
          1'b1, 16'(STACK_DEPTH + 1), 1'b1},
        '{STACK_DEPTH, CH_OPEN_ROUND, ")", STACK_DEPTH - 1, CH_CLOSE_ROUND,
          1'b1, 16'd0, 1'b0},
        '{STACK_DEPTH, CH_OPEN_SQUARE, ")", 0, CH_FILL,
          1'b1, 16'(STACK_DEPTH + 1), 1'b0},
        '{65536, CH_FILL, "(", 0, CH_FILL, 1'b1, POS_MAX, 1'b0},
        '{65535, CH_FILL, "}", 0, CH_FILL, 1'b1, POS_MAX, 1'b0},
        '{0, CH_FILL, "a{b(c)d[e]f}g", 0, CH_FILL, 1'b0, 16'd0, 1'b0},
        '{0, CH_FILL, "((([[[{{{", 0, CH_FILL, 1'b0, 16'd0, 1'b0},
        '{0, CH_FILL, "x]y", 0, CH_FILL, 1'b0, 16'd0, 1'b0},
        '{0, CH_FILL, "{(})", 0, CH_FILL, 1'b0, 16'd0, 1'b0},
        '{0, CH_FILL, "(a\012b)c)", 0, CH_FILL, 1'b0, 16'd0, 1'b0},
        '{0, CH_FILL, "\377\200([{}])", 0, CH_FILL, 1'b0, 16'd0, 1'b0}
    };

    bracket_balance_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_beat  (out_beat)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic kind_t opener_of(logic [7:0] c);
        case (c)
            CH_OPEN_ROUND:  return KIND_ROUND;
            CH_OPEN_CURLY:  return KIND_CURLY;
            CH_OPEN_SQUARE: return KIND_SQUARE;
            default:        return KIND_NONE;
        endcase
    endfunction

    function automatic kind_t closer_of(logic [7:0] c);
        case (c)
            CH_CLOSE_ROUND:  return KIND_ROUND;
            CH_CLOSE_CURLY:  return KIND_CURLY;
            CH_CLOSE_SQUARE: return KIND_SQUARE;
            default:         return KIND_NONE;
        endcase
    endfunction

    function automatic logic [7:0] open_char(kind_t k);
        case (k)
            KIND_ROUND: return CH_OPEN_ROUND;
            KIND_CURLY: return CH_OPEN_CURLY;
            default:    return CH_OPEN_SQUARE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(kind_t k);
        case (k)
            KIND_ROUND: return CH_CLOSE_ROUND;
            KIND_CURLY: return CH_CLOSE_CURLY;
            default:    return CH_CLOSE_SQUARE;
        endcase
    endfunction

    // Advance the bracket state by one byte; return 1 with the verdict on the last byte.
    function automatic bit balance_step(in_beat_t b, output out_beat_t verdict);
        kind_t               ok;
        kind_t               ck;
        logic [POS_BITS-1:0] sel;
        ok      = opener_of(b.ch);
        ck      = closer_of(b.ch);
        verdict = '0;
        if (!err_seen && !ovf_seen && !(b.ch == CH_SPACE || (b.ch >= CH_TAB && b.ch <= CH_CR)))
        begin
            if (byte_pos != POS_MAX)
                byte_pos++;
            if (ok != KIND_NONE)
            begin
                if (open_n == STACK_DEPTH)
                begin
                    ovf_seen = 1'b1;
                    err_at   = byte_pos;
                end
                else
                begin
                    open_pos[open_n]   = byte_pos;
                    open_kinds[open_n] = ok;
                    open_n++;
                end
            end
            else if (ck != KIND_NONE)
            begin
                if (open_n == 0 || open_kinds[open_n - 1] != ck)
                begin
                    err_seen = 1'b1;
                    err_at   = byte_pos;
                end
                else
                    open_n--;
            end
        end
        if (!b.last)
            return 1'b0;
        if (err_seen || ovf_seen)
            sel = err_at;
        else if (open_n > 0)
            sel = open_pos[open_n - 1];
        else
            sel = '0;
        verdict.error_pos = OUT_BITS'(sel);
        verdict.overflow  = ovf_seen;
        open_n   = 0;
        byte_pos = '0;
        err_at   = '0;
        err_seen = 1'b0;
        ovf_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic note_fail(string what, out_beat_t want, out_beat_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%s: expected error_pos=%0d overflow=%0d, got error_pos=%0d overflow=%0d",
                     what, want.error_pos, want.overflow, got.error_pos, got.overflow);
    endtask

    task automatic send_byte(logic [7:0] c, logic l, logic typed, out_beat_t want);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 70)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(5, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_beat    <= '{ch: c, last: l};
        beat_typed <= typed;
        beat_want  <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(logic typed, out_beat_t want);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1, typed, want);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin : watch
        out_beat_t fresh;
        out_beat_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (balance_step(in_beat, fresh))
                    expected_results.push_back(beat_typed ? beat_want : fresh);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    note_fail("unexpected result", '0, out_beat);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_beat.error_pos !== want.error_pos
                        || out_beat.overflow !== want.overflow)
                        note_fail("result mismatch", want, out_beat);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : receiver
        int r;
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                // hold off long enough for the block to back up into its input
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (cycles % 256 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                r = $urandom_range(0, 99);
                if (rx_calm || r >= 30)
                    out_stall <= 1'b0;
                else if (r >= 2)
                    out_stall <= 1'b1;
                else
                begin
                    out_stall <= 1'b1;
                    len = $urandom_range(5, 40);
                    repeat (len) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned n_text;
        int unsigned steps;
        int unsigned maxd;
        int          r;
        int          a;
        logic [7:0]  c;
        kind_t       nest [$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            text_q.delete();
            repeat (rows[i].pre_n) text_q.push_back(rows[i].pre_ch);
            for (int j = 0; j < rows[i].body.len(); j++)
                text_q.push_back(rows[i].body[j]);
            repeat (rows[i].post_n) text_q.push_back(rows[i].post_ch);
            tx_calm = (text_q.size() > 1000);
            send_text(rows[i].typed, '{error_pos: rows[i].want_pos, overflow: rows[i].want_ovf});
        end
        drain();

        tx_calm = 1'b0;
        sent    = 0;
        n_text  = 0;
        while (sent < RANDOM_BYTES)
        begin
            text_q.delete();
            nest.delete();
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                steps = $urandom_range(1, 20);
                repeat (steps) text_q.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                // deep texts fill the stack to around its depth, possibly past it
                maxd  = (r >= 90) ? $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2)
                                  : $urandom_range(1, 8);
                steps = (r >= 90) ? 2 * maxd : $urandom_range(1, 30);
                repeat (steps)
                begin
                    a = $urandom_range(0, 99);
                    if (nest.size() < maxd && (r >= 90 || a < 35))
                    begin
                        nest.push_back(kind_t'($urandom_range(0, 2)));
                        text_q.push_back(open_char(nest[$]));
                    end
                    else if (nest.size() > 0 && a < 65)
                        text_q.push_back(close_char(nest.pop_back()));
                    else
                    begin
                        c = (a % 3 == 0) ? CH_SPACE : 8'($urandom_range(0, 255));
                        if (opener_of(c) != KIND_NONE || closer_of(c) != KIND_NONE)
                            c = CH_FILL;
                        text_q.push_back(c);
                    end
                end
                if (r < 80 || r >= 90)
                    while (nest.size() > 0)
                        text_q.push_back(close_char(nest.pop_back()));
                if (r >= 70 && r < 80)
                begin
                    a = $urandom_range(0, text_q.size() - 1);
                    text_q[a] = $urandom_range(0, 1) ? open_char(kind_t'($urandom_range(0, 2)))
                                                     : close_char(kind_t'($urandom_range(0, 2)));
                end
            end
            if (n_text % 9 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (n_text == 8)
                hold_req = 1'b1;
            send_text(1'b0, '0);
            sent += text_q.size();
            n_text++;
            if (n_text % 30 == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/bbc_pkg.sv
src/bbc_stack_cell.sv
src/bracket_balance_checker.sv
tb/sv/bracket_balance_checker_tb.sv
